[rtl/fbpa_pkg.sv]
// Shared types, codes and defaults for the fixed block pool allocator.
// No dependencies; every other file in rtl/ but fbpa_ram imports this package.
package fbpa_pkg;

  localparam int NUM_BLOCKS_DEF = 256;
  localparam int QUEUE_DEPTH    = 2;
  localparam int ADDR_W         = 32;
  localparam int SIZE_W         = 16;
  localparam int ALIGN_W        = 4;
  localparam int CFG_INDEX_W    = 2;
  localparam int CFG_DATA_W     = 32;

  // func codes on the input channel
  localparam logic [1:0] FUNC_ALLOC   = 2'd0;
  localparam logic [1:0] FUNC_FREE    = 2'd1;
  localparam logic [1:0] FUNC_REBUILD = 2'd2;

  localparam logic [ADDR_W-1:0]  RESET_REGION_START = '0;
  localparam logic [ADDR_W-1:0]  RESET_REGION_END   = '0;
  localparam logic [SIZE_W-1:0]  RESET_BLOCK_SIZE   = 16'd16;
  localparam logic [ALIGN_W-1:0] RESET_ALIGN_LOG2   = '0;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REGION_START = 2'd0,
    CFG_REGION_END   = 2'd1,
    CFG_BLOCK_SIZE   = 2'd2,
    CFG_ALIGN_LOG2   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_FREE    = 2'd1,
    OP_REBUILD = 2'd2,
    OP_NONE    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK            = 2'd0,
    STATUS_EMPTY         = 2'd1,
    STATUS_OUT_OF_REGION = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LINK,
    S_MUL,
    S_ADDR,
    S_LIMIT,
    S_FREE_CHECK,
    S_FREE_DIV,
    S_REB_CHECK,
    S_REB_DIV
  } state_t;

  typedef struct packed {
    logic [ADDR_W-1:0]  region_start;
    logic [ADDR_W-1:0]  region_end;
    logic [SIZE_W-1:0]  block_size;
    logic [ALIGN_W-1:0] alignment_log2;
  } cfg_t;

  typedef struct packed {
    op_t               op;
    logic [ADDR_W-1:0] address;
  } item_t;

endpackage

[rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator: configuration registers,
// front end queue and back end executor. Depends on fbpa_pkg and all rtl/ modules.
//
// Channels: input (in_valid/in_ready, func, address), result (out_valid/out_ready,
// block_address, status) and a configuration write channel (cfg_valid/cfg_ready,
// cfg_index, cfg_data); cfg_ready is always high and register writes are meant
// for idle periods only.
// Each input transfer gives exactly one result, in order. Items queue two deep
// ahead of the back end, which works on one item at a time.
// From acceptance to result valid: allocate answers from idle when empty, goes
// through the multiply and address states from fresh blocks, and first reads the
// link RAM from the free stack; free checks the limit, then answers outside the
// region or runs the 32-step bit-serial divider; rebuild answers when it yields
// no blocks, else runs the divider; unused func answers from idle. A new item is
// taken only after the previous result has gone.
// A stalled receiver holds the result register; the back end then takes no new
// item, while the queue keeps accepting until full.
// Reset: registers return to their defaults (block size 16), the pool holds no
// blocks and the free stack is empty. Link RAM needs no clearing pass.
module fixed_block_pool_allocator #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       func,
  input  logic [fbpa_pkg::ADDR_W-1:0]      address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fbpa_pkg::ADDR_W-1:0]      block_address,
  output logic [1:0]                       status,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fbpa_pkg::*;

  cfg_t  cfg;
  logic  q_valid;
  logic  q_ready;
  item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.region_start   <= RESET_REGION_START;
      cfg.region_end     <= RESET_REGION_END;
      cfg.block_size     <= RESET_BLOCK_SIZE;
      cfg.alignment_log2 <= RESET_ALIGN_LOG2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_REGION_START: cfg.region_start   <= cfg_data[ADDR_W-1:0];
        CFG_REGION_END:   cfg.region_end     <= cfg_data[ADDR_W-1:0];
        CFG_BLOCK_SIZE:   cfg.block_size     <= cfg_data[SIZE_W-1:0];
        CFG_ALIGN_LOG2:   cfg.alignment_log2 <= cfg_data[ALIGN_W-1:0];
        default: ;
      endcase
    end
  end

  fbpa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .address  (address),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_ready  (q_ready)
  );

  fbpa_back #(
    .NUM_BLOCKS (NUM_BLOCKS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_ready       (q_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .block_address (block_address),
    .status        (status)
  );

endmodule

[rtl/fbpa_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/fbpa_front.sv]
// Front end: accepts input transfers, decodes func and queues the items.
// Depends on fbpa_pkg.
module fbpa_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                func,
  input  logic [fbpa_pkg::ADDR_W-1:0] address,
  output logic                      q_valid,
  output fbpa_pkg::item_t           q_item,
  input  logic                      q_ready
);
  import fbpa_pkg::*;

  localparam int QPW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  item_t            queue [QUEUE_DEPTH];
  logic [QPW-1:0]   wr_ptr;
  logic [QPW-1:0]   rd_ptr;
  logic [CNTW-1:0]  fill;
  item_t            new_item;
  logic             push;
  logic             pop;

  always_comb begin
    new_item.address = address;
    case (func)
      FUNC_ALLOC:   new_item.op = OP_ALLOC;
      FUNC_FREE:    new_item.op = OP_FREE;
      FUNC_REBUILD: new_item.op = OP_REBUILD;
      default:      new_item.op = OP_NONE;
    endcase
  end

  assign in_ready = (fill != CNTW'(QUEUE_DEPTH));
  assign q_valid  = (fill != '0);
  assign q_item   = queue[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_item;
    end
  end

endmodule

[rtl/fbpa_div.sv]
// Restoring divider, one quotient bit per cycle: 32-bit dividend, 16-bit divisor.
// Depends on fbpa_pkg. Divisor must be non-zero at start.
module fbpa_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [fbpa_pkg::ADDR_W-1:0] dividend,
  input  logic [fbpa_pkg::SIZE_W-1:0] divisor,
  output logic                        done,
  output logic [fbpa_pkg::ADDR_W-1:0] quotient
);
  import fbpa_pkg::*;

  localparam int STEPS = ADDR_W;
  localparam int CW    = $clog2(STEPS + 1);

  logic              busy;
  logic [CW-1:0]     step_cnt;
  logic [SIZE_W-1:0] rem;
  logic [ADDR_W-1:0] quo;
  logic [SIZE_W-1:0] dvs;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W:0]   diff;
  logic              ge;

  assign trial    = {rem, quo[ADDR_W-1]};
  assign diff     = trial - {1'b0, dvs};
  assign ge       = (trial >= {1'b0, dvs});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= CW'(STEPS);
      end else if (busy) begin
        step_cnt <= step_cnt - 1'b1;
        if (step_cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so 16 bits hold it
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[SIZE_W-1:0] : trial[SIZE_W-1:0];
      quo <= {quo[ADDR_W-2:0], ge};
    end
  end

endmodule

[rtl/fbpa_back.sv]
// Back end: executes queued items against the pool state, free stack and link RAM.
// Depends on fbpa_pkg, fbpa_ram and fbpa_div.
module fbpa_back #(
  parameter int NUM_BLOCKS = fbpa_pkg::NUM_BLOCKS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  fbpa_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  input  fbpa_pkg::item_t             q_item,
  output logic                        q_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [fbpa_pkg::ADDR_W-1:0] block_address,
  output logic [1:0]                  status
);
  import fbpa_pkg::*;

  localparam int AW = $clog2(NUM_BLOCKS);
  localparam int IW = $clog2(NUM_BLOCKS + 1);
  localparam int PW = IW + SIZE_W;
  localparam logic [IW-1:0] NULL_IDX = IW'(NUM_BLOCKS);

  state_t            state, state_next;
  logic              out_valid_r;
  logic              out_valid_next;
  logic [IW-1:0]     stack_head, stack_head_next;
  logic [IW-1:0]     block_count, block_count_next;
  logic [IW-1:0]     fresh_index, fresh_index_next;
  logic [ADDR_W-1:0] aligned_base, aligned_base_next;

  item_t             item, item_next;
  logic [IW-1:0]     alloc_idx, alloc_idx_next;
  logic [PW-1:0]     prod, prod_next;
  logic [ADDR_W:0]   base_ext, base_ext_next;
  logic [ADDR_W-1:0] res_addr, res_addr_next;
  status_t           res_status, res_status_next;

  logic [IW-1:0]     mul_a;
  logic [PW-1:0]     mul_out;
  logic [ADDR_W:0]   mask_ext;
  logic [ADDR_W:0]   lim;

  logic              div_start;
  logic [ADDR_W-1:0] div_dividend;
  logic              div_done;
  logic [ADDR_W-1:0] div_quotient;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [IW-1:0]     ram_rdata;

  fbpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cfg.block_size),
    .done     (div_done),
    .quotient (div_quotient)
  );

  fbpa_ram #(
    .WIDTH (IW),
    .DEPTH (NUM_BLOCKS)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (stack_head),
    .raddr (stack_head[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign mul_out       = PW'(mul_a) * PW'(cfg.block_size);
  assign mask_ext      = ~({(ADDR_W + 1){1'b1}} << cfg.alignment_log2);
  assign lim           = {1'b0, aligned_base} + (ADDR_W + 1)'(prod);
  assign ram_waddr     = div_quotient[AW-1:0];
  assign out_valid     = out_valid_r;
  assign block_address = res_addr;
  assign status        = res_status;

  always_comb begin
    state_next        = state;
    out_valid_next    = out_valid_r;
    stack_head_next   = stack_head;
    block_count_next  = block_count;
    fresh_index_next  = fresh_index;
    aligned_base_next = aligned_base;
    item_next         = item;
    alloc_idx_next    = alloc_idx;
    prod_next         = prod;
    base_ext_next     = base_ext;
    res_addr_next     = res_addr;
    res_status_next   = res_status;
    q_ready           = 1'b0;
    div_start         = 1'b0;
    div_dividend      = '0;
    ram_we            = 1'b0;
    mul_a             = alloc_idx;

    if (out_valid_r && out_ready) begin
      out_valid_next = 1'b0;
    end

    case (state)
      S_IDLE: begin
        if (q_valid && !out_valid_r) begin
          q_ready       = 1'b1;
          item_next     = q_item;
          base_ext_next = ({1'b0, cfg.region_start} + mask_ext) & ~mask_ext;
          case (q_item.op)
            OP_ALLOC: begin
              if (stack_head != NULL_IDX) begin
                alloc_idx_next = stack_head;
                state_next     = S_LINK;
              end else if (fresh_index < block_count) begin
                alloc_idx_next   = fresh_index;
                fresh_index_next = fresh_index + 1'b1;
                state_next       = S_MUL;
              end else begin
                res_addr_next   = '0;
                res_status_next = STATUS_EMPTY;
                out_valid_next  = 1'b1;
              end
            end
            OP_FREE:    state_next = S_LIMIT;
            OP_REBUILD: state_next = S_REB_CHECK;
            default: begin
              res_addr_next   = '0;
              res_status_next = STATUS_OK;
              out_valid_next  = 1'b1;
            end
          endcase
        end
      end
      S_LINK: begin
        // link RAM read of the popped head has landed
        stack_head_next = ram_rdata;
        state_next      = S_MUL;
      end
      S_MUL: begin
        mul_a      = alloc_idx;
        prod_next  = mul_out;
        state_next = S_ADDR;
      end
      S_ADDR: begin
        res_addr_next   = aligned_base + ADDR_W'(prod);
        res_status_next = STATUS_OK;
        out_valid_next  = 1'b1;
        state_next      = S_IDLE;
      end
      S_LIMIT: begin
        mul_a      = block_count;
        prod_next  = mul_out;
        state_next = S_FREE_CHECK;
      end
      S_FREE_CHECK: begin
        if (item.address < aligned_base || {1'b0, item.address} >= lim) begin
          res_addr_next   = '0;
          res_status_next = STATUS_OUT_OF_REGION;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end else begin
          div_start    = 1'b1;
          div_dividend = item.address - aligned_base;
          state_next   = S_FREE_DIV;
        end
      end
      S_FREE_DIV: begin
        if (div_done) begin
          // quotient is below block_count, hence a valid index
          ram_we          = 1'b1;
          stack_head_next = div_quotient[IW-1:0];
          res_addr_next   = '0;
          res_status_next = STATUS_OK;
          out_valid_next  = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_REB_CHECK: begin
        aligned_base_next = base_ext[ADDR_W-1:0];
        fresh_index_next  = '0;
        stack_head_next   = NULL_IDX;
        if (base_ext[ADDR_W] || base_ext[ADDR_W-1:0] >= cfg.region_end ||
            cfg.block_size == '0) begin
          block_count_next = '0;
          res_addr_next    = '0;
          res_status_next  = STATUS_OK;
          out_valid_next   = 1'b1;
          state_next       = S_IDLE;
        end else begin
          div_start    = 1'b1;
          div_dividend = cfg.region_end - base_ext[ADDR_W-1:0];
          state_next   = S_REB_DIV;
        end
      end
      S_REB_DIV: begin
        if (div_done) begin
          block_count_next = (div_quotient > ADDR_W'(NUM_BLOCKS)) ? NULL_IDX :
                             div_quotient[IW-1:0];
          res_addr_next    = '0;
          res_status_next  = STATUS_OK;
          out_valid_next   = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid_r  <= 1'b0;
      stack_head   <= NULL_IDX;
      block_count  <= '0;
      fresh_index  <= '0;
      aligned_base <= '0;
    end else begin
      state        <= state_next;
      out_valid_r  <= out_valid_next;
      stack_head   <= stack_head_next;
      block_count  <= block_count_next;
      fresh_index  <= fresh_index_next;
      aligned_base <= aligned_base_next;
    end
  end

  always_ff @(posedge clk) begin
    item       <= item_next;
    alloc_idx  <= alloc_idx_next;
    prod       <= prod_next;
    base_ext   <= base_ext_next;
    res_addr   <= res_addr_next;
    res_status <= res_status_next;
  end

  a_head_range: assert property (@(posedge clk) disable iff (rst)
    stack_head <= NULL_IDX)
    else $error("free stack head beyond null marker");

  a_fresh_bound: assert property (@(posedge clk) disable iff (rst)
    fresh_index <= block_count)
    else $error("fresh index ran past block count");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_FREE_DIV || state == S_REB_DIV))
    else $error("divider finished with no waiting operation");

  a_push_in_pool: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (div_quotient < ADDR_W'(block_count)))
    else $error("pushed block index outside pool");

  a_link_after_pop: assert property (@(posedge clk) disable iff (rst)
    (state == S_LINK) |-> ($past(stack_head) != NULL_IDX))
    else $error("link read with empty free stack");

endmodule

[tb/testbench.sv]
// Self-checking testbench for fixed_block_pool_allocator: predicts each result from a
// behavioural pool model and compares every result transfer. Depends on fbpa_pkg and rtl/.
// Directed cases and a receiver hold-off first, then randomised region phases and a second hold-off.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fbpa_pkg::*;

  localparam int NUM_BLOCKS = NUM_BLOCKS_DEF;
  localparam int LINK_AW = $clog2(NUM_BLOCKS);
  localparam logic [12:0] NO_BLOCK = 13'(NUM_BLOCKS);

  typedef struct {
    logic [ADDR_W-1:0] addr;
    status_t           st;
  } pool_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func = OP_ALLOC;
  logic [ADDR_W-1:0] address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [ADDR_W-1:0] block_address;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = CFG_REGION_START;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // register copies and pool state
  logic [31:0] reg_start = RESET_REGION_START;
  logic [31:0] reg_end   = RESET_REGION_END;
  logic [15:0] reg_size  = RESET_BLOCK_SIZE;
  logic [3:0]  reg_align = RESET_ALIGN_LOG2;
  logic [31:0] pool_base  = '0;
  logic [12:0] pool_count = '0;
  logic [12:0] next_fresh = '0;
  logic [12:0] free_top   = NO_BLOCK;
  logic [12:0] free_link [NUM_BLOCKS];

  pool_reply_t expected_replies[$];
  logic [31:0] live_blocks[$];
  logic [31:0] freed_last = '0;
  int mismatches = 0;
  bit gaps_on = 1'b1;
  int hold_cycles = 0;
  bit holding = 1'b0;

  fixed_block_pool_allocator dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .func(func), .address(address),
    .out_valid(out_valid), .out_ready(out_ready),
    .block_address(block_address), .status(status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic void pool_predict(input op_t op, input logic [31:0] addr);
    pool_reply_t r;
    logic [63:0] mask, base, lim, cnt, off;
    logic [12:0] idx;
    r.addr = '0;
    r.st   = STATUS_OK;
    case (op)
      OP_ALLOC: begin
        if (free_top < NO_BLOCK) begin
          idx = free_top;
          free_top = free_link[idx[LINK_AW-1:0]];
        end else if (next_fresh < pool_count) begin
          idx = next_fresh;
          next_fresh = next_fresh + 13'd1;
        end else begin
          idx = NO_BLOCK;
          r.st = STATUS_EMPTY;
        end
        if (r.st == STATUS_OK) begin
          r.addr = 32'(64'(pool_base) + 64'(idx) * 64'(reg_size));
          live_blocks.push_back(r.addr);
        end
      end
      OP_FREE: begin
        lim = 64'(pool_base) + 64'(pool_count) * 64'(reg_size);
        if (pool_count == 0 || reg_size == 0 || addr < pool_base || 64'(addr) >= lim) begin
          r.st = STATUS_OUT_OF_REGION;
        end else begin
          off = (64'(addr) - 64'(pool_base)) / 64'(reg_size);
          if (off < 64'(NUM_BLOCKS)) begin
            free_link[off[LINK_AW-1:0]] = free_top;
            free_top = off[12:0];
          end else begin
            r.st = STATUS_OUT_OF_REGION;
          end
        end
      end
      OP_REBUILD: begin
        mask = (64'd1 << reg_align) - 64'd1;
        base = (64'(reg_start) + mask) & ~mask;
        cnt  = '0;
        if (base <= 64'hFFFF_FFFF && base < 64'(reg_end) && reg_size != 0) begin
          cnt = (64'(reg_end) - base) / 64'(reg_size);
          if (cnt > 64'(NUM_BLOCKS)) cnt = 64'(NUM_BLOCKS);
        end
        pool_base  = base[31:0];
        pool_count = cnt[12:0];
        next_fresh = '0;
        free_top   = NO_BLOCK;
        live_blocks.delete();
      end
      default: ;
    endcase
    expected_replies.push_back(r);
  endfunction

  // valid stays high after a transfer so that back-to-back items need no second assignment
  task automatic send_item(input op_t op, input logic [31:0] addr);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= op;
    address  <= addr;
    do @(posedge clk); while (!in_ready);
    pool_predict(op, addr);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_replies.size() != 0);
  endtask

  task automatic reg_write(input cfg_reg_t idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_REGION_START: reg_start = data;
      CFG_REGION_END:   reg_end   = data;
      CFG_BLOCK_SIZE:   reg_size  = data[15:0];
      CFG_ALIGN_LOG2:   reg_align = data[3:0];
      default: ;
    endcase
  endtask

  task automatic program_region(input logic [31:0] start, input logic [31:0] stop,
                                input logic [15:0] size, input logic [3:0] align);
    wait_drain();
    reg_write(CFG_REGION_START, start);
    reg_write(CFG_REGION_END, stop);
    reg_write(CFG_BLOCK_SIZE, 32'(size));
    reg_write(CFG_ALIGN_LOG2, 32'(align));
    cfg_valid <= 1'b0;
  endtask

  // result sink: random stalls, plus a counted hold-off on request
  initial begin : result_sink
    int stall;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        holding = 1'b1;
        out_ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
        holding = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pool_reply_t exp_r;
    if (!rst && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        $display("%0t: unexpected result, expected none, got block_address %h status %0d",
                 $time, block_address, status);
        mismatches++;
      end else begin
        exp_r = expected_replies.pop_front();
        if (block_address !== exp_r.addr) begin
          $display("%0t: block_address expected %h, got %h", $time, exp_r.addr, block_address);
          mismatches++;
        end
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d, got %0d", $time, exp_r.st, status);
          mismatches++;
        end
      end
    end
  end

  task automatic test_before_rebuild();
    send_item(OP_ALLOC, $urandom);
    send_item(OP_FREE, 32'h0000_0000);
    send_item(OP_NONE, 32'hFFFF_FFFF);
    // rebuild from reset registers: empty region
    send_item(OP_REBUILD, $urandom);
    send_item(OP_ALLOC, $urandom);
  endtask

  task automatic test_small_pool();
    // base rounds up to 0x1010, three whole blocks plus a partial one
    program_region(32'h0000_1003, 32'h0000_1045, 16'd16, 4'd4);
    send_item(OP_REBUILD, $urandom);
    repeat (4) send_item(OP_ALLOC, $urandom);
    send_item(OP_FREE, 32'h0000_1021);
    send_item(OP_FREE, 32'h0000_1040);
    send_item(OP_FREE, 32'h0000_100F);
    send_item(OP_ALLOC, $urandom);
    // double free goes unchecked
    send_item(OP_FREE, 32'h0000_1010);
    send_item(OP_FREE, 32'h0000_1010);
    repeat (2) send_item(OP_ALLOC, $urandom);
  endtask

  task automatic test_region_edges();
    program_region(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'd16, 4'd12);
    send_item(OP_REBUILD, $urandom);
    send_item(OP_ALLOC, $urandom);
    program_region(32'h0000_0000, 32'h0000_1000, 16'd0, 4'd0);
    send_item(OP_REBUILD, $urandom);
    send_item(OP_ALLOC, $urandom);
    send_item(OP_FREE, 32'h0000_0000);
    program_region(32'h0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 4'd12);
    send_item(OP_REBUILD, $urandom);
    send_item(OP_FREE, 32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    bit saved;
    program_region(32'h0000_2000, 32'h0000_2200, 16'd64, 4'd6);
    send_item(OP_REBUILD, $urandom);
    saved = gaps_on;
    gaps_on = 1'b0;
    hold_cycles = 150;
    // drop valid while the sink settles into its hold-off
    in_valid <= 1'b0;
    do @(posedge clk); while (!holding);
    repeat (4) send_item(OP_ALLOC, $urandom);
    send_item(OP_FREE, 32'h0000_2040);
    send_item(OP_FREE, 32'h0000_2085);
    repeat (4) send_item(OP_ALLOC, $urandom);
    // sender stands back until every result is in
    wait_drain();
    gaps_on = saved;
  endtask

  task automatic random_item();
    int r;
    int k;
    logic [63:0] edge_addr;
    r = $urandom_range(0, 99);
    if (r < 45 || (r < 80 && live_blocks.size() == 0)) begin
      send_item(OP_ALLOC, $urandom);
    end else if (r < 80) begin
      k = $urandom_range(0, live_blocks.size() - 1);
      freed_last = live_blocks[k];
      live_blocks.delete(k);
      if ($urandom_range(0, 1) && reg_size > 1)
        send_item(OP_FREE, freed_last + $urandom_range(0, reg_size - 1));
      else
        send_item(OP_FREE, freed_last);
    end else if (r < 88) begin
      edge_addr = 64'(pool_base) + 64'(pool_count) * 64'(reg_size);
      case ($urandom_range(0, 2))
        0: send_item(OP_FREE, $urandom);
        1: send_item(OP_FREE, 32'(edge_addr) - $urandom_range(0, 2));
        default: send_item(OP_FREE, pool_base - $urandom_range(0, 1));
      endcase
    end else if (r < 92) begin
      send_item(OP_FREE, freed_last);
    end else if (r < 97) begin
      send_item(OP_REBUILD, $urandom);
    end else begin
      send_item(OP_NONE, $urandom);
    end
  endtask

  task automatic test_random_pool();
    logic [31:0] start, stop;
    logic [15:0] size;
    logic [3:0] align;
    logic [63:0] span;
    int blocks;
    for (int phase = 0; phase < 20; phase++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: size = 16'($urandom_range(1, 16));
        3, 4, 5, 6: size = 16'($urandom_range(1, 4096));
        7: size = 16'hFFFF;
        8: size = 16'd1;
        default: size = 16'($urandom);
      endcase
      align  = 4'($urandom_range(0, 12));
      start  = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF);
      blocks = $urandom_range(0, 300);
      span   = 64'(start) + (64'd1 << align) + 64'(blocks) * 64'(size)
               + 64'($urandom_range(0, 15));
      stop   = (span > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : span[31:0];
      if ($urandom_range(0, 9) == 0) stop = $urandom;
      if (phase == 0) begin
        start = '0; stop = 32'hFFFF_FFFF; size = 16'd1; align = 4'd0;
      end else if (phase == 1) begin
        start = 32'hFFFF_0001; stop = 32'hFFFF_FFFF; size = 16'd16; align = 4'd12;
      end
      program_region(start, stop, size, align);
      gaps_on = ($urandom_range(0, 4) != 0);
      // now and then keep the old pool under the new registers
      if ($urandom_range(0, 9) != 0) send_item(OP_REBUILD, $urandom);
      repeat ($urandom_range(80, 120)) random_item();
    end
    gaps_on = 1'b1;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_before_rebuild();
    test_small_pool();
    test_region_edges();
    test_backpressure();
    test_random_pool();
    test_backpressure();
    wait_drain();
    repeat (60) @(posedge clk);
    if (mismatches == 0) begin
      $display("fixed_block_pool_allocator: match");
    end else begin
      $display("fixed_block_pool_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #(25_000_000);
    $display("fixed_block_pool_allocator: mismatch");
    $finish;
  end

endmodule
